### src/ols_pkg.sv
// Shared action codes, status codes and controller/datapath handshake types.
package ols_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam logic [2:0] ACT_INS_FRONT = 3'd0;
  localparam logic [2:0] ACT_APPEND    = 3'd1;
  localparam logic [2:0] ACT_REM_FRONT = 3'd2;
  localparam logic [2:0] ACT_REM_MATCH = 3'd3;
  localparam logic [2:0] ACT_SEARCH    = 3'd4;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  typedef struct packed {
    logic       load;
    logic       idx_inc;
    logic       rd_en;
    logic       rd_next;
    logic       wr_front;
    logic       wr_back;
    logic       wr_shift;
    logic       head_inc;
    logic       head_dec;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       set_res;
    logic [1:0] res_status;
    logic       res_found;
    logic       emit;
  } ols_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       empty;
    logic       full;
    logic       match;
    logic       last;
    logic       out_free;
  } ols_sts_t;

endpackage

### src/ols_datapath.sv
// List storage: circular entry memory, head and count registers, walk index, result register.
module ols_datapath #(
  parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ols_pkg::ols_cmd_t  cmd,
  output ols_pkg::ols_sts_t  sts,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [4:0]         out_entry_count
);
  import ols_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0]   mem [CAPACITY];
  logic [31:0]   mem_q_r;
  logic [2:0]    action_r;
  logic [31:0]   value_r;
  logic [IW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [1:0]    res_status_r;
  logic          res_found_r;
  logic          out_valid_r;
  logic [1:0]    out_status_r;
  logic          out_found_r;
  logic [4:0]    out_count_r;

  logic [IW-1:0] head_m1;
  logic [IW-1:0] head_p1;
  logic [IW-1:0] rd_addr;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          wr_en;
  logic [CW:0]   idx_p1;

  function automatic logic [IW-1:0] phys(input logic [IW-1:0] h, input logic [CW:0] x);
    logic [IW+1:0] s;
    s = {2'b00, h} + (IW + 2)'(x);
    if (s >= (IW + 2)'(CAPACITY)) begin
      s = s - (IW + 2)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  assign idx_p1  = {1'b0, idx_r} + (CW + 1)'(1);
  assign head_m1 = (head_r == '0) ? IW'(CAPACITY - 1) : head_r - IW'(1);
  assign head_p1 = (head_r == IW'(CAPACITY - 1)) ? '0 : head_r + IW'(1);
  assign rd_addr = cmd.rd_next ? phys(head_r, idx_p1) : phys(head_r, {1'b0, idx_r});

  always_comb begin
    wr_en   = cmd.wr_front | cmd.wr_back | cmd.wr_shift;
    wr_data = cmd.wr_shift ? mem_q_r : value_r;
    if (cmd.wr_front) begin
      wr_addr = head_m1;
    end else if (cmd.wr_back) begin
      wr_addr = phys(head_r, {1'b0, count_r});
    end else begin
      wr_addr = phys(head_r, {1'b0, idx_r});
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r <= in_action;
      value_r  <= in_operand_value;
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_found_r  <= cmd.res_found;
    end
    if (cmd.emit) begin
      out_status_r <= res_status_r;
      out_found_r  <= res_found_r;
      out_count_r  <= 5'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.head_inc) begin
        head_r <= head_p1;
      end else if (cmd.head_dec) begin
        head_r <= head_m1;
      end
      if (cmd.cnt_inc) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.cnt_dec) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.load) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_p1[CW-1:0];
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.action   = action_r;
  assign sts.empty    = (count_r == '0);
  assign sts.full     = (count_r >= CW'(CAPACITY));
  assign sts.match    = (mem_q_r == value_r);
  assign sts.last     = (idx_p1 >= {1'b0, count_r});
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found       = out_found_r;
  assign out_entry_count = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == $past(count_r)) || (count_r == $past(count_r) + CW'(1)) ||
    (count_r == $past(count_r) - CW'(1)))
    else $error("entry count moved by more than one");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= IW'(CAPACITY - 1))
    else $error("head pointer out of range");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !cmd.emit)
    else $error("result overwritten while stalled");

endmodule

### src/ols_ctrl.sv
// Sequencing controller: decodes each request and walks the list for search and removal.
module ols_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ols_pkg::ols_sts_t sts,
  output ols_pkg::ols_cmd_t cmd
);
  import ols_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_CMP    = 3'd2;
  localparam logic [2:0] S_SHIFT  = 3'd3;
  localparam logic [2:0] S_SHWR   = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_res = 1'b1;
        state_nxt   = S_RESP;
        case (sts.action)
          ACT_INS_FRONT: begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_front = 1'b1;
              cmd.head_dec = 1'b1;
              cmd.cnt_inc  = 1'b1;
            end
          end
          ACT_APPEND: begin
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.wr_back = 1'b1;
              cmd.cnt_inc = 1'b1;
            end
          end
          ACT_REM_FRONT: begin
            if (sts.empty) begin
              cmd.res_status = ST_ABSENT;
            end else begin
              cmd.head_inc = 1'b1;
              cmd.cnt_dec  = 1'b1;
            end
          end
          ACT_REM_MATCH, ACT_SEARCH: begin
            if (sts.empty) begin
              cmd.res_status = (sts.action == ACT_REM_MATCH) ? ST_ABSENT : ST_DONE;
            end else begin
              cmd.set_res = 1'b0;
              cmd.rd_en   = 1'b1;
              state_nxt   = S_CMP;
            end
          end
          default: ;
        endcase
      end
      S_CMP: begin
        if (sts.match) begin
          if (sts.action == ACT_SEARCH) begin
            cmd.set_res   = 1'b1;
            cmd.res_found = 1'b1;
            state_nxt     = S_RESP;
          end else begin
            state_nxt = S_SHIFT;
          end
        end else if (sts.last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = (sts.action == ACT_REM_MATCH) ? ST_ABSENT : ST_DONE;
          state_nxt      = S_RESP;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          cmd.idx_inc = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.last) begin
          cmd.cnt_dec   = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res_found = 1'b1;
          state_nxt     = S_RESP;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_nxt   = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_nxt    = S_SHIFT;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/ordered_list_store.sv
// Top level of the ordered list store: controller plus storage datapath.
// The list lives in a circular single-port-write, single-port-read memory with a head
// pointer, so insert at front, append, and remove front each go through the accept,
// decode and respond steps from acceptance to result. Search reads and compares the
// entries one at a time from the front, one memory read per entry, until a match or
// the last entry. Remove-first-match walks to the match, then moves each later entry
// one slot toward the front with one read and one write per moved entry, bounded by
// the single memory port, and finally drops the last slot. The respond step holds for
// as long as a stalled result occupies the output register. One request is in flight
// at a time; the next request is taken once the previous result sits in the output
// register. No clearing pass is needed after reset.
module ordered_list_store #(
  parameter int CAPACITY = ols_pkg::CAPACITY_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_operand_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic               out_found,
  output logic [4:0]         out_entry_count
);
  import ols_pkg::*;

  ols_cmd_t cmd;
  ols_sts_t sts;

  ols_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ols_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_action),
    .in_operand_value (in_operand_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_found        (out_found),
    .out_entry_count  (out_entry_count)
  );

endmodule
